/* hdl/ckmh_pkg.sv */
`timescale 1ns / 1ps

package ckmh_pkg;

  localparam int MAX_ROWS      = 16;
  localparam int ROW_W         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int POSITION_BITS = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam int KMER_W   = 64;
  localparam int BUCKET_W = 44;
  localparam int POS_OUT_W = 16;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_SHIFT = 2'd2;

  localparam logic [5:0] KMER_LEN_RST   = 6'd31;
  localparam logic [4:0] NUM_HASHES_RST = 5'd10;
  localparam logic [5:0] HASH_SHIFT_RST = 6'd36;

  // input op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BASE = 1'b1;

  typedef enum logic {
    KIND_LOAD,
    KIND_HASH
  } ckmh_kind_e;

  // one queue entry: a coefficient load or a canonical k-mer to hash
  typedef struct packed {
    ckmh_kind_e               kind;
    logic [ROW_W-1:0]         idx;
    logic [ROW_W-1:0]         rows_m1;
    logic [KMER_W-1:0]        val_a;
    logic [KMER_W-1:0]        val_b;
    logic [5:0]               bbits;
    logic [5:0]               shift;
    logic [POSITION_BITS-1:0] pos;
    logic                     mate;
  } ckmh_job_t;

  function automatic logic [1:0] base_code(input logic [7:0] letter);
    logic [1:0] code;
    case (letter)
      "C", "c": code = 2'd1;
      "G", "g": code = 2'd2;
      "T", "t": code = 2'd3;
      default:  code = 2'd0;
    endcase
    return code;
  endfunction

endpackage

/* hdl/canonical_kmer_multiply_shift_hasher.sv */
`timescale 1ns / 1ps
// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+------------------------------------
// input    | in        | in_valid_i / in_stall_o      | op, base, read flags, mate, coefs
// result   | out       | out_valid_o / out_stall_i    | hash_row, bucket, position, mate, last
// config   | in        | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// a base that completes a k-mer, or that carries read_end, issues num_hashes rows (1 to 16,
// 10 after reset) into the shared multiply pipeline, one row per cycle through the single
// coefficient memory port while no stalled result freezes the back; other bases only update
// the front state, and a coefficient load is queued and then written in the back.
// reset restores the register defaults and clears the k-mer state; coefficients hold garbage
// until loaded. a stalled result freezes the back; input stalls when the 4-entry queue fills.

module canonical_kmer_multiply_shift_hasher import ckmh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [7:0]            base_i,
  input  logic                  read_start_i,
  input  logic                  read_end_i,
  input  logic                  mate_i,
  input  logic [3:0]            coef_index_i,
  input  logic [63:0]           coef_mult_i,
  input  logic [63:0]           coef_add_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [3:0]            hash_row_o,
  output logic [43:0]           bucket_o,
  output logic [15:0]           kmer_position_o,
  output logic                  read_mate_o,
  output logic                  last_of_run_o
);

  logic      push, full, pop, empty;
  ckmh_job_t push_job, head_job;

  assign cfg_ready_o = 1'b1;

  ckmh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .base_i       (base_i),
    .read_start_i (read_start_i),
    .read_end_i   (read_end_i),
    .mate_i       (mate_i),
    .coef_index_i (coef_index_i),
    .coef_mult_i  (coef_mult_i),
    .coef_add_i   (coef_add_i),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  ckmh_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head_job),
    .empty_o    (empty)
  );

  ckmh_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_job),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hash_row_o      (hash_row_o),
    .bucket_o        (bucket_o),
    .kmer_position_o (kmer_position_o),
    .read_mate_o     (read_mate_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

/* hdl/ckmh_front.sv */
`timescale 1ns / 1ps

module ckmh_front import ckmh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [7:0]            base_i,
  input  logic                  read_start_i,
  input  logic                  read_end_i,
  input  logic                  mate_i,
  input  logic [3:0]            coef_index_i,
  input  logic [KMER_W-1:0]     coef_mult_i,
  input  logic [KMER_W-1:0]     coef_add_i,
  input  logic                  full_i,
  output logic                  push_o,
  output ckmh_job_t             job_o
);

  logic [5:0] kmer_len_q;
  logic [4:0] num_hashes_q;
  logic [5:0] hash_shift_q;

  logic [KMER_W-1:0]        fwd_q, fwd_d;
  logic [KMER_W-1:0]        rev_q, rev_d;
  logic [5:0]               seen_q, seen_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;

  logic                     accept;
  logic [5:0]               k_eff;
  logic [6:0]               two_k;
  logic [KMER_W-1:0]        mask2k;
  logic [KMER_W-1:0]        fwd0, rev0;
  logic [5:0]               seen0;
  logic [POSITION_BITS-1:0] pos0;
  logic [1:0]               code, comp;
  logic                     emit;
  logic [KMER_W-1:0]        canon;
  logic [7:0]               bsum;
  logic [5:0]               bbits;
  logic [ROW_W-1:0]         rows_m1;
  logic                     idx_ok;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    k_eff = kmer_len_q;
    if (kmer_len_q == 6'd0) begin
      k_eff = 6'd1;
    end else if (kmer_len_q > 6'd32) begin
      k_eff = 6'd32;
    end
    two_k  = {k_eff, 1'b0};
    mask2k = (two_k == 7'd64) ? '1 : ((64'd1 << two_k) - 64'd1);

    // read_start clears the rolling state before the base goes in
    fwd0  = read_start_i ? '0 : fwd_q;
    rev0  = read_start_i ? '0 : rev_q;
    seen0 = read_start_i ? '0 : seen_q;
    pos0  = read_start_i ? '0 : pos_q;

    code = base_code(base_i);
    comp = ~code;

    if (seen0 >= k_eff) begin
      fwd_d  = {fwd0[KMER_W-3:0], code} & mask2k;
      rev_d  = ((rev0 >> 2) | ({62'd0, comp} << (two_k - 7'd2))) & mask2k;
      seen_d = seen0;
    end else begin
      fwd_d  = {fwd0[KMER_W-3:0], code};
      rev_d  = rev0 | ({62'd0, comp} << {seen0, 1'b0});
      seen_d = seen0 + 6'd1;
    end

    emit  = (seen_d >= k_eff) || read_end_i;
    canon = (fwd_d > rev_d) ? fwd_d : rev_d;
    pos_d = (emit && (pos0 != POS_MAX)) ? pos0 + 1'b1 : pos0;

    bsum  = {1'b0, two_k} + {2'b00, hash_shift_q};
    bbits = (bsum > 8'd64) ? 6'(bsum - 8'd64) : 6'd0;

    if (num_hashes_q == 5'd0) begin
      rows_m1 = '0;
    end else if (32'(num_hashes_q) > MAX_ROWS) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(num_hashes_q - 5'd1);
    end

    idx_ok = 32'(coef_index_i) < MAX_ROWS;
  end

  always_comb begin
    job_o = '0;
    if (op_i == OP_LOAD) begin
      job_o.kind  = KIND_LOAD;
      job_o.idx   = ROW_W'(coef_index_i);
      job_o.val_a = coef_mult_i;
      job_o.val_b = coef_add_i;
      push_o      = accept && idx_ok;
    end else begin
      job_o.kind    = KIND_HASH;
      job_o.rows_m1 = rows_m1;
      job_o.val_a   = canon;
      job_o.bbits   = bbits;
      job_o.shift   = hash_shift_q;
      job_o.pos     = pos0;
      job_o.mate    = mate_i;
      push_o        = accept && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q   <= KMER_LEN_RST;
      num_hashes_q <= NUM_HASHES_RST;
      hash_shift_q <= HASH_SHIFT_RST;
      fwd_q        <= '0;
      rev_q        <= '0;
      seen_q       <= '0;
      pos_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_KMER_LEN:   kmer_len_q   <= cfg_data_i;
          CFG_NUM_HASHES: num_hashes_q <= cfg_data_i[4:0];
          CFG_HASH_SHIFT: hash_shift_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && (op_i == OP_BASE)) begin
        fwd_q  <= fwd_d;
        rev_q  <= rev_d;
        seen_q <= seen_d;
        pos_q  <= pos_d;
      end
    end
  end

endmodule

/* hdl/ckmh_queue.sv */
`timescale 1ns / 1ps

module ckmh_queue import ckmh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ckmh_job_t push_job_i,
  output logic      full_o,
  input  logic      pop_i,
  output ckmh_job_t head_o,
  output logic      empty_o
);

  ckmh_job_t          entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]    count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/ckmh_back.sv */
`timescale 1ns / 1ps

module ckmh_back import ckmh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ckmh_job_t             head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [3:0]            hash_row_o,
  output logic [BUCKET_W-1:0]   bucket_o,
  output logic [POS_OUT_W-1:0]  kmer_position_o,
  output logic                  read_mate_o,
  output logic                  last_of_run_o
);

  typedef struct packed {
    logic [ROW_W-1:0]         row;
    logic                     last;
    logic [5:0]               shift;
    logic [POSITION_BITS-1:0] pos;
    logic                     mate;
  } meta_t;

  logic [2*KMER_W-1:0] coef_mem [MAX_ROWS];

  logic             en;
  logic             issue, load;
  logic [ROW_W-1:0] row_q;
  meta_t            issue_meta;

  // stage 1: coefficient read
  logic              s1_valid_q;
  meta_t             s1_meta_q;
  logic [KMER_W-1:0] s1_x_q;
  logic [5:0]        s1_bbits_q;
  logic [2*KMER_W-1:0] s1_coef_q;
  logic [KMER_W-1:0] s1_a, s1_b, s1_bmask;

  // stage 2: partial products
  logic              s2_valid_q;
  meta_t             s2_meta_q;
  logic [KMER_W-1:0] s2_pll_q, s2_bm_q;
  logic [31:0]       s2_plh_q, s2_phl_q;

  // stage 3: partial sums
  logic              s3_valid_q;
  meta_t             s3_meta_q;
  logic [KMER_W-1:0] s3_low_q;
  logic [31:0]       s3_cross_q;
  logic [KMER_W-1:0] s3_sum;

  logic                    out_valid_q;
  logic [ROW_W-1:0]        out_row_q;
  logic [BUCKET_W-1:0]     out_bucket_q;
  logic [POSITION_BITS-1:0] out_pos_q;
  logic                    out_mate_q, out_last_q;

  // whole pipeline freezes while a result waits on a stalled sink
  assign en    = !(out_valid_q && out_stall_i);
  assign load  = en && !empty_i && (head_i.kind == KIND_LOAD);
  assign issue = en && !empty_i && (head_i.kind == KIND_HASH);
  assign pop_o = load || (issue && (row_q == head_i.rows_m1));

  always_comb begin
    issue_meta       = '0;
    issue_meta.row   = row_q;
    issue_meta.last  = (row_q == head_i.rows_m1);
    issue_meta.shift = head_i.shift;
    issue_meta.pos   = head_i.pos;
    issue_meta.mate  = head_i.mate;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      coef_mem[head_i.idx] <= {head_i.val_a, head_i.val_b};
    end
    if (en) begin
      s1_coef_q <= coef_mem[row_q];
    end
  end

  assign s1_a     = s1_coef_q[2*KMER_W-1:KMER_W];
  assign s1_b     = s1_coef_q[KMER_W-1:0];
  assign s1_bmask = (64'd1 << s1_bbits_q) - 64'd1;
  assign s3_sum   = s3_low_q + {s3_cross_q, 32'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_meta_q  <= issue_meta;
      s1_x_q     <= head_i.val_a;
      s1_bbits_q <= head_i.bbits;

      // low 64 bits of a*x from three 32x32 products
      s2_meta_q <= s1_meta_q;
      s2_pll_q  <= 64'(s1_a[31:0]) * 64'(s1_x_q[31:0]);
      s2_plh_q  <= 32'(s1_a[31:0] * s1_x_q[63:32]);
      s2_phl_q  <= 32'(s1_a[63:32] * s1_x_q[31:0]);
      s2_bm_q   <= s1_b & s1_bmask;

      s3_meta_q  <= s2_meta_q;
      s3_low_q   <= s2_pll_q + s2_bm_q;
      s3_cross_q <= s2_plh_q + s2_phl_q;

      out_row_q    <= s3_meta_q.row;
      out_bucket_q <= BUCKET_W'(s3_sum >> s3_meta_q.shift);
      out_pos_q    <= s3_meta_q.pos;
      out_mate_q   <= s3_meta_q.mate;
      out_last_q   <= s3_meta_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      if (pop_o) begin
        row_q <= '0;
      end else if (issue) begin
        row_q <= row_q + 1'b1;
      end
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hash_row_o      = 4'(out_row_q);
  assign bucket_o        = out_bucket_q;
  assign kmer_position_o = POS_OUT_W'(out_pos_q);
  assign read_mate_o     = out_mate_q;
  assign last_of_run_o   = out_last_q;

endmodule

/* hdl/ckmh_checker.sv */
`timescale 1ns / 1ps

module ckmh_checker import ckmh_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  op_i,
  input logic [7:0]            base_i,
  input logic                  read_start_i,
  input logic                  read_end_i,
  input logic                  mate_i,
  input logic [3:0]            coef_index_i,
  input logic [63:0]           coef_mult_i,
  input logic [63:0]           coef_add_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [3:0]            hash_row_o,
  input logic [43:0]           bucket_o,
  input logic [15:0]           kmer_position_o,
  input logic                  read_mate_o,
  input logic                  last_of_run_o
);

  logic out_xfer;
  assign out_xfer = out_valid_o && !out_stall_i;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bucket_o) && $stable(hash_row_o)
      && $stable(last_of_run_o))
    else $error("result changed while stalled");

  // the highest row always closes its k-mer
  a_top_row_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (hash_row_o == 4'(MAX_ROWS - 1)) |-> last_of_run_o)
    else $error("top row without last_of_run");

  // rows of one k-mer come back to back in order with the same position and mate
  a_row_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !last_of_run_o) ##1 out_valid_o |->
      (hash_row_o == $past(hash_row_o) + 4'd1) && (kmer_position_o == $past(kmer_position_o))
      && (read_mate_o == $past(read_mate_o)))
    else $error("row sequence broken within a k-mer");

  // a new k-mer starts at row zero
  a_row_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last_of_run_o) ##1 out_valid_o |-> hash_row_o == 4'd0)
    else $error("k-mer did not start at row zero");

endmodule

bind canonical_kmer_multiply_shift_hasher ckmh_checker u_ckmh_checker (.*);
